// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define DSF_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dsf assertion failed");

// property checked at every rising edge, reset included
`define DSF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("dsf assertion failed");

`endif

// File: hw/rtl/dsf_pkg.sv
// types and constants for the delimited sentence framer
// no dependencies; imported by every framer module
package dsf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CHARS = 3'd0,
        CFG_START_COUNT = 3'd1,
        CFG_END_NEEDLE  = 3'd2,
        CFG_END_LEN     = 3'd3,
        CFG_MAX_LENGTH  = 3'd4
    } cfg_reg_t;

    // reset values of the configuration registers
    localparam logic [31:0] START_CHARS_RST = 32'd36;
    localparam logic [2:0]  START_COUNT_RST = 3'd1;
    localparam logic [63:0] END_NEEDLE_RST  = 64'd2573;
    localparam logic [3:0]  END_LEN_RST     = 4'd2;
    localparam logic [15:0] MAX_LENGTH_RST  = 16'd82;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        first_of_sentence;
        logic        last_of_sentence;
        logic [31:0] sentence_offset;
    } out_t;

endpackage

// File: hw/rtl/dsf_end_match.sv
// end delimiter compare over the window of newest sentence bytes
// depends on dsf_pkg
module dsf_end_match #(
    parameter int END_MAX = 8
) (
    input  logic [END_MAX-1:0][7:0] win_bytes,
    input  logic [63:0]             end_needle,
    input  logic [3:0]              end_len_eff,
    input  logic [15:0]             sent_len,
    output logic                    match
);
    import dsf_pkg::*;

    localparam int IDX_W = (END_MAX > 1) ? $clog2(END_MAX) : 1;

    logic bytes_ok;

    // win_bytes[0] is the newest byte; needle byte i pairs with win[len-1-i]
    always_comb begin
        logic [3:0] idx;
        idx      = '0;
        bytes_ok = 1'b1;
        for (int i = 0; i < END_MAX; i++) begin
            if (4'(i) < end_len_eff) begin
                idx = end_len_eff - 4'(i) - 4'd1;
                if (win_bytes[idx[IDX_W-1:0]] != end_needle[8*i +: 8]) begin
                    bytes_ok = 1'b0;
                end
            end
        end
    end

    assign match = bytes_ok && (sent_len >= {12'd0, end_len_eff});

endmodule

// File: hw/rtl/delimited_sentence_framer_unit.sv
// delimited sentence framer: start characters open; end needle, length or end of stream closes
// 2 register stages: input register, then result register, which takes a byte once it is free
// throughput: one byte per cycle while results are taken, limited by one state update per byte
// dropped bytes produce no result beat; a blocked result beat with a byte waiting
// in the input register stalls the input side
// reset (aresetn low, synchronous) empties both registers, leaves any sentence,
// zeroes stream position and loads the configuration defaults
module delimited_sentence_framer_unit #(
    parameter int END_MAX   = 8,
    parameter int START_MAX = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dsf_pkg::in_t                       s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output dsf_pkg::out_t                      m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dsf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dsf_pkg::*;

    localparam int START_LIM = (START_MAX < 4) ? START_MAX : 4;
    localparam int RECENT_D  = (END_MAX > 1) ? END_MAX - 1 : 1;

    // configuration
    logic [31:0] start_chars_reg;
    logic [2:0]  start_count_reg;
    logic [63:0] end_needle_reg;
    logic [3:0]  end_len_reg;
    logic [15:0] len_limit_reg;

    // input register
    logic in_valid_reg, in_valid_next;
    in_t  in_beat_reg, in_beat_next;

    // framing state
    logic        in_sentence_reg, in_sentence_next;
    logic [7:0]  recent_reg [RECENT_D];
    logic [7:0]  recent_next [RECENT_D];
    logic [15:0] sent_len_reg, sent_len_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] start_off_reg, start_off_next;

    // result register
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    logic                   out_free, take_beat;
    logic                   hit, opening, passing, match, last;
    logic [3:0]             el_eff;
    logic [15:0]            ml_eff, len_base, len_new;
    logic [END_MAX-1:0][7:0] win;

    assign out_free  = !m_valid_reg || m_ready;
    assign take_beat = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < START_LIM; i++) begin
            if ((3'(i) < start_count_reg) &&
                (start_chars_reg[8*i +: 8] == in_beat_reg.in_byte)) begin
                hit = 1'b1;
            end
        end
    end

    assign opening = !in_sentence_reg && hit;
    assign passing = in_sentence_reg || hit;

    always_comb begin
        if (end_len_reg == 4'd0) begin
            el_eff = 4'd1;
        end else if (end_len_reg > 4'(END_MAX)) begin
            el_eff = 4'(END_MAX);
        end else begin
            el_eff = end_len_reg;
        end
    end

    assign ml_eff   = (len_limit_reg < {12'd0, el_eff}) ? {12'd0, el_eff} : len_limit_reg;
    assign len_base = opening ? 16'd0 : sent_len_reg;
    assign len_new  = (len_base == 16'hFFFF) ? len_base : len_base + 16'd1;

    // newest byte first; older bytes only from inside the current sentence
    always_comb begin
        win[0] = in_beat_reg.in_byte;
        for (int i = 1; i < END_MAX; i++) begin
            win[i] = opening ? 8'd0 : recent_reg[i-1];
        end
    end

    dsf_end_match #(
        .END_MAX (END_MAX)
    ) u_end_match (
        .win_bytes   (win),
        .end_needle  (end_needle_reg),
        .end_len_eff (el_eff),
        .sent_len    (len_new),
        .match       (match)
    );

    assign last = match || (len_new >= ml_eff) || in_beat_reg.end_of_stream;

    always_comb begin
        in_valid_next    = in_valid_reg;
        in_beat_next     = in_beat_reg;
        in_sentence_next = in_sentence_reg;
        recent_next      = recent_reg;
        sent_len_next    = sent_len_reg;
        pos_next         = pos_reg;
        start_off_next   = start_off_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_beat_next  = s_data;
        end else if (take_beat) begin
            in_valid_next = 1'b0;
        end

        if (out_free) begin
            m_valid_next = take_beat && passing;
        end

        if (take_beat) begin
            pos_next = in_beat_reg.end_of_stream ? 32'd0 : pos_reg + 32'd1;
            if (passing) begin
                in_sentence_next = !last;
                sent_len_next    = len_new;
                recent_next[0]   = in_beat_reg.in_byte;
                for (int i = 1; i < RECENT_D; i++) begin
                    recent_next[i] = win[i];
                end
                if (opening) begin
                    start_off_next = pos_reg;
                end
                m_data_next.out_byte          = in_beat_reg.in_byte;
                m_data_next.first_of_sentence = opening;
                m_data_next.last_of_sentence  = last;
                m_data_next.sentence_offset   = opening ? pos_reg : start_off_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_chars_reg <= START_CHARS_RST;
            start_count_reg <= START_COUNT_RST;
            end_needle_reg  <= END_NEEDLE_RST;
            end_len_reg     <= END_LEN_RST;
            len_limit_reg   <= MAX_LENGTH_RST;
            in_valid_reg    <= 1'b0;
            in_sentence_reg <= 1'b0;
            sent_len_reg    <= '0;
            pos_reg         <= '0;
            start_off_reg   <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < RECENT_D; i++) begin
                recent_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_START_CHARS: start_chars_reg <= cfg_data[31:0];
                    CFG_START_COUNT: start_count_reg <= cfg_data[2:0];
                    CFG_END_NEEDLE:  end_needle_reg  <= cfg_data;
                    CFG_END_LEN:     end_len_reg     <= cfg_data[3:0];
                    CFG_MAX_LENGTH:  len_limit_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            in_valid_reg    <= in_valid_next;
            in_sentence_reg <= in_sentence_next;
            sent_len_reg    <= sent_len_next;
            pos_reg         <= pos_next;
            start_off_reg   <= start_off_next;
            m_valid_reg     <= m_valid_next;
            recent_reg      <= recent_next;
        end
        in_beat_reg <= in_beat_next;
        m_data_reg  <= m_data_next;
    end

endmodule

// File: hw/rtl/dsf_checker.sv
// port-level checks for the delimited sentence framer, bound to the top level
// depends on dsf_pkg and assert_macros.svh
`include "assert_macros.svh"

module dsf_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input dsf_pkg::out_t m_data
);
    import dsf_pkg::*;

    // a held result beat keeps its valid and payload
    `DSF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // the input side stalls only behind a blocked result beat
    `DSF_ASSERT(a_stall_cause, aclk, aresetn, !s_ready |-> m_valid && !m_ready)

    // reset empties the result register
    `DSF_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // an empty pipeline never refuses a beat
    `DSF_ASSERT(a_idle_ready, aclk, aresetn, !m_valid && $past(!s_valid) |-> s_ready)

endmodule

bind delimited_sentence_framer_unit dsf_checker u_dsf_checker (.*);

// File: test/tb_delimited_sentence_framer_unit.sv
// self-checking testbench for delimited_sentence_framer_unit: directed and random byte
// streams, a predictor of the framing rules, and a scoreboard of expected result beats
// depends on dsf_pkg and the framer RTL only

class framer_scoreboard #(int END_MAX = 8, int START_MAX = 4);
    logic [31:0] start_chars;
    logic [2:0]  start_count;
    logic [63:0] end_needle;
    logic [3:0]  end_len;
    logic [15:0] len_limit;

    bit          in_sentence;
    logic [7:0]  recent [END_MAX];
    logic [15:0] sentence_len;
    logic [31:0] stream_pos;
    logic [31:0] start_offset;

    dsf_pkg::out_t expected_beats[$];
    int errors;

    function new();
        start_chars  = dsf_pkg::START_CHARS_RST;
        start_count  = dsf_pkg::START_COUNT_RST;
        end_needle   = dsf_pkg::END_NEEDLE_RST;
        end_len      = dsf_pkg::END_LEN_RST;
        len_limit    = dsf_pkg::MAX_LENGTH_RST;
        in_sentence  = 1'b0;
        foreach (recent[i]) recent[i] = '0;
        sentence_len = '0;
        stream_pos   = '0;
        start_offset = '0;
        errors       = 0;
    endfunction

    function void set_register(dsf_pkg::cfg_reg_t idx, logic [63:0] value);
        case (idx)
            dsf_pkg::CFG_START_CHARS: start_chars = value[31:0];
            dsf_pkg::CFG_START_COUNT: start_count = value[2:0];
            dsf_pkg::CFG_END_NEEDLE:  end_needle  = value;
            dsf_pkg::CFG_END_LEN:     end_len     = value[3:0];
            dsf_pkg::CFG_MAX_LENGTH:  len_limit   = value[15:0];
            default: ;
        endcase
    endfunction

    function int delimiter_len();
        int el;
        el = (end_len == 0) ? 1 : int'(end_len);
        if (el > END_MAX)
            el = END_MAX;
        return el;
    endfunction

    function bit is_opener(logic [7:0] b);
        int n;
        n = (START_MAX < 4) ? START_MAX : 4;
        if (start_count < n)
            n = start_count;
        for (int i = 0; i < n; i++)
            if (start_chars[8*i +: 8] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    // frames one accepted input byte; a passed byte queues one expected beat
    function void note_byte(dsf_pkg::in_t item);
        logic [31:0]   pos;
        logic [7:0]    win [END_MAX];
        int            el;
        int            ml;
        bit            first_b;
        bit            match;
        bit            last_b;
        dsf_pkg::out_t beat;
        pos = stream_pos;
        stream_pos = pos + 1;
        first_b = 1'b0;
        if (!in_sentence) begin
            if (!is_opener(item.in_byte)) begin
                if (item.end_of_stream)
                    stream_pos = '0;
                return;
            end
            in_sentence  = 1'b1;
            first_b      = 1'b1;
            start_offset = pos;
            sentence_len = '0;
            foreach (recent[i]) recent[i] = '0;
        end
        el = delimiter_len();
        ml = (int'(len_limit) < el) ? el : int'(len_limit);
        if (sentence_len != 16'hFFFF)
            sentence_len++;
        win[0] = item.in_byte;
        for (int i = 1; i < END_MAX; i++)
            win[i] = recent[i-1];
        // needle byte 0 lines up with the oldest of the el newest bytes
        match = (int'(sentence_len) >= el);
        for (int i = 0; i < el; i++)
            if (win[el-1-i] != end_needle[8*i +: 8])
                match = 1'b0;
        last_b = match || int'(sentence_len) >= ml || item.end_of_stream;
        for (int i = END_MAX - 1; i > 0; i--)
            recent[i] = recent[i-1];
        recent[0] = item.in_byte;
        beat.out_byte          = item.in_byte;
        beat.first_of_sentence = first_b;
        beat.last_of_sentence  = last_b;
        beat.sentence_offset   = start_offset;
        expected_beats = {expected_beats, beat};
        if (last_b)
            in_sentence = 1'b0;
        if (item.end_of_stream)
            stream_pos = '0;
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (errors <= 100)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_beat(dsf_pkg::out_t got);
        dsf_pkg::out_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing pending", got));
            return;
        end
        want = expected_beats.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte got %h want %h",
                got.out_byte, want.out_byte));
        if (got.first_of_sentence !== want.first_of_sentence)
            report_mismatch($sformatf("first_of_sentence got %b want %b (byte %h)",
                got.first_of_sentence, want.first_of_sentence, want.out_byte));
        if (got.last_of_sentence !== want.last_of_sentence)
            report_mismatch($sformatf("last_of_sentence got %b want %b (byte %h)",
                got.last_of_sentence, want.last_of_sentence, want.out_byte));
        if (got.sentence_offset !== want.sentence_offset)
            report_mismatch($sformatf("sentence_offset got %0d want %0d",
                got.sentence_offset, want.sentence_offset));
    endtask
endclass

module tb_delimited_sentence_framer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dsf_pkg::*;

    localparam int RANDOM_BYTES = 1650;
    localparam int PHASES       = 10;
    localparam int HOLD_CYCLES  = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic rx_ready;
    logic hold_off;
    bit   tx_burst;
    bit   rx_burst;
    int   sent_bytes;

    framer_scoreboard sentences = new();

    assign m_ready = rx_ready && !hold_off;

    delimited_sentence_framer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input bit eos);
        int   gap;
        in_t  item;
        item.in_byte       = b;
        item.end_of_stream = eos;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sentences.note_byte(item);
        sent_bytes++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sentences.set_register(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drain all results, then give a dropped byte time to leave the pipeline
    task automatic settle();
        s_valid <= 1'b0;
        while (sentences.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_opener();
        int n;
        n = (sentences.start_count > 4) ? 4 : int'(sentences.start_count);
        if (n == 0)
            return 8'($urandom);
        return sentences.start_chars[8*$urandom_range(0, n-1) +: 8];
    endfunction

    // noise, an opener, a body and usually the delimiter
    task automatic send_sentence();
        int noise;
        int body;
        int el;
        int cut;
        bit close;
        bit eos_here;
        noise = $urandom_range(0, 3);
        repeat (noise) send_byte(8'($urandom), $urandom_range(0, 31) == 0);
        el       = sentences.delimiter_len();
        body     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 12);
        close    = ($urandom_range(0, 7) != 0);
        eos_here = ($urandom_range(0, 11) == 0);
        send_byte(pick_opener(), 1'b0);
        for (int i = 0; i < body; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                // leading part of the delimiter only
                cut = $urandom_range(0, el - 1);
                for (int k = 0; k < cut; k++)
                    send_byte(sentences.end_needle[8*k +: 8], 1'b0);
            end else begin
                send_byte(8'($urandom), 1'b0);
            end
        end
        if (close) begin
            for (int k = 0; k < el; k++)
                send_byte(sentences.end_needle[8*k +: 8], eos_here && k == el - 1);
        end else if (eos_here) begin
            send_byte(8'($urandom), 1'b1);
        end
    endtask

    // result side
    initial begin
        int wait_cycles;
        rx_ready = 1'b0;
        rx_burst = 1'b0;
        @(negedge aclk);
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            wait_cycles = rx_burst ? 0 : $urandom_range(0, 8);
            if (wait_cycles > 0) begin
                rx_ready <= 1'b0;
                repeat (wait_cycles) @(negedge aclk);
            end
            rx_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
            sentences.check_beat(m_data);
            @(negedge aclk);
        end
    end

    initial begin
        logic [31:0] chars;
        logic [2:0]  count;
        logic [63:0] needle;
        logic [3:0]  dlen;
        logic [15:0] maxlen;
        int          sent_mark;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        hold_off   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        tx_burst   = 1'b0;
        sent_bytes = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default settings: '$' opens, CR LF closes
        send_byte(8'h78, 1'b0);
        send_byte(8'h24, 1'b0);
        send_byte(8'h47, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);   // dropped last byte restarts the stream
        send_byte(8'h24, 1'b1);   // opens and closes on the same beat
        send_byte(8'h24, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h0A, 1'b0);

        // no start characters at all
        settle();
        write_reg(CFG_START_COUNT, 64'd0);
        send_byte(8'h24, 1'b1);

        // count above four, zero delimiter length, zero max length
        settle();
        write_reg(CFG_START_CHARS, 64'hFF00_2124);
        write_reg(CFG_START_COUNT, 64'd7);
        write_reg(CFG_END_LEN, 64'd0);
        write_reg(CFG_END_NEEDLE, 64'd0);
        write_reg(CFG_MAX_LENGTH, 64'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h21, 1'b0);
        send_byte(8'h55, 1'b0);

        // oversized delimiter length, needle with a zero byte, longest sentence
        settle();
        write_reg(CFG_END_LEN, 64'd15);
        write_reg(CFG_END_NEEDLE, 64'hFFFF_FFFF_FFFF_FF00);
        write_reg(CFG_MAX_LENGTH, 64'hFFFF);
        send_byte(8'h00, 1'b0);
        repeat (7) send_byte(8'hFF, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph == 0) begin
                chars  = '0;
                count  = 3'd1;
                needle = '0;
                dlen   = 4'd1;
                maxlen = 16'd1;
            end else if (ph == 1) begin
                chars  = '1;
                count  = 3'd4;
                needle = '1;
                dlen   = 4'd8;
                maxlen = 16'hFFFF;
            end else begin
                chars  = $urandom;
                count  = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
                needle = {$urandom, $urandom};
                for (int k = 0; k < 8; k++)
                    if ($urandom_range(0, 3) == 0)
                        needle[8*k +: 8] = 8'h00;
                dlen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
                case ($urandom_range(0, 3))
                    0: maxlen = 16'($urandom_range(0, 8));
                    1: maxlen = 16'($urandom_range(9, 40));
                    2: maxlen = 16'hFFFF;
                    default: maxlen = 16'($urandom);
                endcase
            end
            write_reg(CFG_START_CHARS, 64'(chars));
            write_reg(CFG_START_COUNT, 64'(count));
            write_reg(CFG_END_NEEDLE, needle);
            write_reg(CFG_END_LEN, 64'(dlen));
            write_reg(CFG_MAX_LENGTH, 64'(maxlen));
            tx_burst = ($urandom_range(0, 3) == 0);
            if (ph == 1) begin
                // stall the result side long enough for the input side to back up
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(negedge aclk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            sent_mark = sent_bytes;
            while (sent_bytes - sent_mark < RANDOM_BYTES / PHASES)
                send_sentence();
        end

        s_valid <= 1'b0;
        for (int n = 0; n < 2000 && sentences.pending() != 0; n++)
            @(negedge aclk);
        if (sentences.pending() != 0)
            sentences.report_mismatch($sformatf("%0d expected beats never arrived",
                sentences.pending()));
        repeat (8) @(negedge aclk);
        if (sentences.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dsf_pkg.sv
hw/rtl/dsf_end_match.sv
hw/rtl/delimited_sentence_framer_unit.sv
hw/rtl/dsf_checker.sv
test/tb_delimited_sentence_framer_unit.sv
